// ===== rtl/tmgr_pkg.sv =====
// Shared constants, payload types and a helper function of the text-mode glyph rasterizer.
package tmgr_pkg;

   localparam int COLUMNS     = 80;
   localparam int GLYPH_ROWS  = 16;
   localparam int GLYPH_WIDTH = 8;

   localparam int FONT_DEPTH  = 4096;
   localparam int FONT_AW     = $clog2(FONT_DEPTH);
   localparam int FONT_DW     = 8;
   localparam int CELL_W      = 11;
   localparam int CODE_W      = 8;
   localparam int ATTR_W      = 8;
   localparam int COLOR_W     = 4;
   localparam int PIX_W       = GLYPH_WIDTH * COLOR_W;
   localparam int ADDR_W      = 18;
   localparam int ROW_W       = $clog2(GLYPH_ROWS);

   localparam int LINE_PIXELS = COLUMNS * GLYPH_WIDTH;
   localparam int ROW_STRIDE  = LINE_PIXELS * GLYPH_ROWS;

   localparam logic FUNC_LOAD = 1'b0;
   localparam logic FUNC_DRAW = 1'b1;

   typedef struct packed {
      logic                func;
      logic [FONT_AW-1:0]  font_addr;
      logic [FONT_DW-1:0]  font_byte;
      logic [CELL_W-1:0]   cell_index;
      logic [CODE_W-1:0]   char_code;
      logic [ATTR_W-1:0]   attribute;
   } req_type;

   typedef struct packed {
      logic [PIX_W-1:0]    pixel_colors;
      logic [ADDR_W-1:0]   pixel_addr;
      logic                last_row;
   } rsp_type;

   // Commands from the sequencer to the address unit.
   typedef struct packed {
      logic                start;
      logic [CELL_W-1:0]   cell_index;
      logic                advance;
   } addr_ctrl_type;

   typedef struct packed {
      logic                ready;
      logic [ADDR_W-1:0]   pixel_addr;
   } addr_stat_type;

   // Expands one font row into palette indices, leftmost pixel in the top nibble.
   function automatic logic [PIX_W-1:0] colorize(input logic [FONT_DW-1:0] bits,
                                                 input logic [ATTR_W-1:0] attr);
      logic [PIX_W-1:0]   packed_row;
      logic [COLOR_W-1:0] fg;
      logic [COLOR_W-1:0] bg;
      fg = attr[3:0];
      bg = {1'b0, attr[6:4]};
      packed_row = '0;
      for (int x = 0; x < GLYPH_WIDTH; x++) begin
         packed_row[x*COLOR_W +: COLOR_W] = bits[x] ? fg : bg;
      end
      return packed_row;
   endfunction

endpackage

// ===== rtl/tmgr_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module tmgr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/tmgr_addr.sv =====
// Iterative pixel address unit: splits the cell number by repeated subtraction; one shared adder builds the address.
module tmgr_addr (
   input  logic                    clock,
   input  logic                    reset,
   input  tmgr_pkg::addr_ctrl_type ctrl,
   output tmgr_pkg::addr_stat_type stat
);
   import tmgr_pkg::*;

   typedef enum logic [3:0] {
      AU_IDLE  = 4'b0001,
      AU_DIV   = 4'b0010,
      AU_COL   = 4'b0100,
      AU_READY = 4'b1000
   } phase_type;

   phase_type          phase_ff, phase_in;
   logic [CELL_W-1:0]  rem_ff, rem_in;
   logic [ADDR_W-1:0]  base_ff, base_in;
   logic [ADDR_W-1:0]  operand;
   logic [ADDR_W-1:0]  sum;
   logic               rem_ge;

   assign rem_ge = rem_ff >= CELL_W'(COLUMNS);

   // The one adder serves the row stride, the column offset and the glyph line step.
   always_comb begin
      case (phase_ff)
         AU_DIV:  operand = ADDR_W'(ROW_STRIDE);
         AU_COL:  operand = ADDR_W'(rem_ff * GLYPH_WIDTH);
         default: operand = ADDR_W'(LINE_PIXELS);
      endcase
   end

   assign sum = base_ff + operand;

   always_comb begin
      phase_in = phase_ff;
      rem_in   = rem_ff;
      base_in  = base_ff;
      if (ctrl.start) begin
         phase_in = AU_DIV;
         rem_in   = ctrl.cell_index;
         base_in  = '0;
      end else begin
         case (phase_ff)
            AU_IDLE: begin
            end
            AU_DIV: begin
               if (rem_ge) begin
                  rem_in  = rem_ff - CELL_W'(COLUMNS);
                  base_in = sum;
               end else begin
                  phase_in = AU_COL;
               end
            end
            AU_COL: begin
               base_in  = sum;
               phase_in = AU_READY;
            end
            AU_READY: begin
               if (ctrl.advance) begin
                  base_in = sum;
               end
            end
            default: phase_in = AU_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= AU_IDLE;
      end else begin
         phase_ff <= phase_in;
      end
      rem_ff  <= rem_in;
      base_ff <= base_in;
   end

   assign stat.ready      = phase_ff == AU_READY;
   assign stat.pixel_addr = base_ff;

endmodule

// ===== rtl/text_mode_glyph_rasterizer.sv =====
// Top level: sequencer, font store and result register of the text-mode glyph rasterizer.
// A load beat writes the font store; it gives no result.
// A draw beat first computes the pixel address in the subtract-and-add address unit,
// then gives one font read and one result beat per cycle for sixteen rows while the output is not stalled.
// While a draw runs, req_stall holds off the next beat until the final row has been emitted.
// Reset clears the sequencer and the result valid flag; the font store is not cleared.
module text_mode_glyph_rasterizer (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  tmgr_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output tmgr_pkg::rsp_type rsp_data
);
   import tmgr_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_ADDR = 3'b010,
      ST_ROWS = 3'b100
   } state_type;

   state_type           state_ff, state_in;
   logic [CODE_W-1:0]   char_ff, char_in;
   logic [ATTR_W-1:0]   attr_ff, attr_in;
   logic [ROW_W-1:0]    row_ff, row_in;
   logic                data_vld_ff, data_vld_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_data_ff, rsp_data_in;

   addr_ctrl_type       addr_ctrl;
   addr_stat_type       addr_stat;

   logic                req_accept;
   logic                out_free;
   logic                last;
   logic                emit;
   logic                rd_en;
   logic [ROW_W:0]      rd_row;
   logic [FONT_AW-1:0]  rd_addr;
   logic [FONT_DW-1:0]  rd_data;
   logic                wr_en;

   assign req_stall  = state_ff != ST_IDLE;
   assign req_accept = req_valid && !req_stall;
   assign wr_en      = req_accept && req_data.func == FUNC_LOAD;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign last     = row_ff == ROW_W'(GLYPH_ROWS - 1);
   assign emit     = state_ff == ST_ROWS && data_vld_ff && out_free;

   // While a row is held, the read for the following row goes out as it is taken.
   assign rd_en   = state_ff == ST_ROWS && (!data_vld_ff || (out_free && !last));
   assign rd_row  = data_vld_ff ? {1'b0, row_ff} + 1'b1 : {1'b0, row_ff};
   assign rd_addr = FONT_AW'(char_ff * GLYPH_ROWS + rd_row);

   assign addr_ctrl.start      = req_accept && req_data.func == FUNC_DRAW;
   assign addr_ctrl.cell_index = req_data.cell_index;
   assign addr_ctrl.advance    = emit;

   tmgr_addr u_addr (
      .clock (clock),
      .reset (reset),
      .ctrl  (addr_ctrl),
      .stat  (addr_stat)
   );

   tmgr_ram #(
      .WIDTH (FONT_DW),
      .DEPTH (FONT_DEPTH)
   ) u_font (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (req_data.font_addr),
      .wr_data (req_data.font_byte),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      state_in     = state_ff;
      char_in      = char_ff;
      attr_in      = attr_ff;
      row_in       = row_ff;
      data_vld_in  = data_vld_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      case (state_ff)
         ST_IDLE: begin
            if (addr_ctrl.start) begin
               char_in  = req_data.char_code;
               attr_in  = req_data.attribute;
               state_in = ST_ADDR;
            end
         end
         ST_ADDR: begin
            if (addr_stat.ready) begin
               row_in      = '0;
               data_vld_in = 1'b0;
               state_in    = ST_ROWS;
            end
         end
         ST_ROWS: begin
            if (emit) begin
               rsp_valid_in             = 1'b1;
               rsp_data_in.pixel_colors = colorize(rd_data, attr_ff);
               rsp_data_in.pixel_addr   = addr_stat.pixel_addr;
               rsp_data_in.last_row     = last;
               row_in                   = row_ff + 1'b1;
               if (last) begin
                  data_vld_in = 1'b0;
                  state_in    = ST_IDLE;
               end
            end else if (!data_vld_ff) begin
               data_vld_in = 1'b1;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         data_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         data_vld_ff  <= data_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      char_ff     <= char_in;
      attr_ff     <= attr_in;
      row_ff      <= row_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // The final row of a cell returns the sequencer to idle.
   a_last_row_idle: assert property (@(posedge clock) disable iff (reset)
      emit && last |=> state_ff == ST_IDLE)
      else $error("sequencer did not return to idle after the final row");

   // Rows are only produced once the address unit has finished its division.
   a_rows_addr_ready: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_ROWS |-> addr_stat.ready)
      else $error("row phase entered before the pixel address was ready");

   // An accepted draw beat starts the address phase.
   a_draw_starts: assert property (@(posedge clock) disable iff (reset)
      addr_ctrl.start |=> state_ff == ST_ADDR && !addr_stat.ready)
      else $error("draw beat did not start the address phase");

   // A beat is only emitted while the font read data holds a valid row.
   a_emit_has_data: assert property (@(posedge clock) disable iff (reset)
      emit |-> data_vld_ff && $past(rd_en || data_vld_ff))
      else $error("result emitted without font read data");

endmodule
